>>> src/pdm_cic_pkg.sv
// ----------------------------------------------------------------------------
// PDM to PCM CIC decimator package
// Shared constants, register map and small helper functions.
// ----------------------------------------------------------------------------
package pdm_cic_pkg;

    // Default widths for the top-level parameters
    localparam int ACC_WIDTH_DEF = 32;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths
    localparam int PCM_W   = 22;
    localparam int RATIO_W = 8;
    localparam int BYTE_W  = 8;
    localparam int DELTA_W = 5;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [0:0] REG_DECIM_RATIO = 1'b0;

    // Reset value of the decimation ratio
    localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd8;

    // Ratio of zero behaves as a ratio of one
    function automatic logic [RATIO_W-1:0] ratio_sat(input logic [RATIO_W-1:0] ratio);
        logic [RATIO_W-1:0] r;
        r = ratio;
        if (ratio == '0) begin
            r = RATIO_W'(1);
        end
        return r;
    endfunction

    // Byte with n ones maps to 2*n - 8, range -8..8
    function automatic logic signed [DELTA_W-1:0] byte_delta(input logic [BYTE_W-1:0] b);
        logic [3:0] ones;
        ones = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            ones = ones + 4'(b[i]);
        end
        return DELTA_W'(signed'({1'b0, ones, 1'b0})) - DELTA_W'(8);
    endfunction

endpackage

>>> src/pdm_to_pcm_cic_decimator.sv
// ----------------------------------------------------------------------------
// pdm_to_pcm_cic_decimator
// Second-order CIC decimator with byte pre-summing. Each PDM word is split
// into bytes; all byte integrator steps are resolved combinationally and the
// integrator snapshots at sample points are queued. The two comb stages run
// at the output, one sample per transaction.
// ----------------------------------------------------------------------------
// Samples of an accepted word are registered in the sample buffer first.
// Throughput: one word per cycle while each word yields at most one sample
//   (decim_ratio >= bytes per word) and the buffer is not full; a word
//   yielding more samples stays in the two-entry buffer until all are taken.
// Reset (aresetn low, synchronous): integrators, combs and buffer cleared,
//   decim_ratio = 8 and the byte countdown reloaded to 8.
// ----------------------------------------------------------------------------
module pdm_to_pcm_cic_decimator #(
    parameter int ACC_WIDTH = pdm_cic_pkg::ACC_WIDTH_DEF,
    parameter int WORD_BITS = pdm_cic_pkg::WORD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // PDM input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [WORD_BITS-1:0]                   s_pdm_word,
    // PCM result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pdm_cic_pkg::PCM_W-1:0]   m_pcm_sample,
    output logic                                   m_last_of_word,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pdm_cic_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pdm_cic_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pdm_cic_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                   pready
);
    import pdm_cic_pkg::*;

    localparam int NB    = WORD_BITS / BYTE_W;
    localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int CNT_W = $clog2(NB + 1);
    localparam int P_W   = $clog2(8 * NB + 1) + 1;
    localparam int Q_W   = $clog2(4 * NB * (NB + 1) + 1) + 1;

    // Control and state registers
    logic [RATIO_W-1:0]    ratio_reg;
    logic [RATIO_W-1:0]    countdown_reg, countdown_next;
    logic [ACC_WIDTH-1:0]  integ_one_reg, integ_one_next;
    logic [ACC_WIDTH-1:0]  integ_two_reg, integ_two_next;
    logic [PCM_W-1:0]      comb_one_d0_reg, comb_one_d1_reg;
    logic [PCM_W-1:0]      comb_two_d0_reg, comb_two_d1_reg;

    // Sample buffer: two word bursts
    logic [PCM_W-1:0]      buf_sample_reg [2][NB];
    logic [CNT_W-1:0]      buf_len_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            buf_cnt_reg, buf_cnt_next;
    logic [IDX_W-1:0]      rd_idx_reg;

    // Per-byte pre-sums
    logic signed [P_W-1:0] p_sum [NB];
    logic signed [Q_W-1:0] q_sum [NB];
    logic [ACC_WIDTH-1:0]  integ_two_at [NB];

    // Burst built from the current word
    logic [PCM_W-1:0]      burst_sample [NB];
    logic [CNT_W-1:0]      burst_len;

    logic                  cfg_write;
    logic                  in_accept, out_accept;
    logic                  push, pop;
    logic [PCM_W-1:0]      head_x, comb_one_out, comb_two_out;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;

    // Register readback
    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_DECIM_RATIO) begin
            prdata[RATIO_W-1:0] = ratio_reg;
        end
    end

    // Running sums of byte deltas and of first-integrator offsets
    always_comb begin
        logic signed [P_W-1:0] p_run;
        logic signed [Q_W-1:0] q_run;
        p_run = '0;
        q_run = '0;
        for (int k = 0; k < NB; k++) begin
            p_run    = p_run + P_W'(byte_delta(s_pdm_word[BYTE_W*k +: BYTE_W]));
            q_run    = q_run + Q_W'(p_run);
            p_sum[k] = p_run;
            q_sum[k] = q_run;
        end
    end

    // Second integrator after byte k: I2 + (k+1)*I1 + Q_k
    for (genvar k = 0; k < NB; k++) begin : g_integ
        assign integ_two_at[k] = integ_two_reg
                               + ACC_WIDTH'(k + 1) * integ_one_reg
                               + ACC_WIDTH'(q_sum[k]);
    end

    assign integ_one_next = integ_one_reg + ACC_WIDTH'(p_sum[NB-1]);
    assign integ_two_next = integ_two_at[NB-1];

    // Sample points within the word and burst packing
    always_comb begin
        logic [RATIO_W-1:0] cd;
        logic [CNT_W-1:0]   n;
        cd = countdown_reg;
        n  = '0;
        for (int k = 0; k < NB; k++) begin
            burst_sample[k] = '0;
        end
        for (int k = 0; k < NB; k++) begin
            if (cd <= RATIO_W'(1)) begin
                cd = ratio_sat(ratio_reg);
                burst_sample[n[IDX_W-1:0]] = integ_two_at[k][PCM_W-1:0];
                n = n + CNT_W'(1);
            end else begin
                cd = cd - RATIO_W'(1);
            end
        end
        countdown_next = cd;
        burst_len      = n;
    end

    // Buffer handshake
    assign s_ready = (buf_cnt_reg != 2'd2);
    assign m_valid = (buf_cnt_reg != 2'd0);
    assign push    = in_accept && (burst_len != '0);
    assign m_last_of_word = (CNT_W'(rd_idx_reg) + CNT_W'(1) == buf_len_reg[rd_ptr_reg]);
    assign pop     = out_accept && m_last_of_word;

    always_comb begin
        buf_cnt_next = buf_cnt_reg;
        if (push && !pop) begin
            buf_cnt_next = buf_cnt_reg + 2'd1;
        end else if (pop && !push) begin
            buf_cnt_next = buf_cnt_reg - 2'd1;
        end
    end

    // Comb stages on the head sample, low PCM bits suffice for the output
    assign head_x       = buf_sample_reg[rd_ptr_reg][rd_idx_reg];
    assign comb_one_out = head_x - comb_one_d1_reg;
    assign comb_two_out = comb_one_out - comb_two_d1_reg;
    assign m_pcm_sample = signed'(comb_two_out);

    // State and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg       <= RATIO_RESET;
            countdown_reg   <= ratio_sat(RATIO_RESET);
            integ_one_reg   <= '0;
            integ_two_reg   <= '0;
            comb_one_d0_reg <= '0;
            comb_one_d1_reg <= '0;
            comb_two_d0_reg <= '0;
            comb_two_d1_reg <= '0;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            buf_cnt_reg     <= '0;
        end else begin
            if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_DECIM_RATIO) begin
                ratio_reg     <= pwdata[RATIO_W-1:0];
                countdown_reg <= ratio_sat(pwdata[RATIO_W-1:0]);
            end else if (in_accept) begin
                countdown_reg <= countdown_next;
            end
            if (in_accept) begin
                integ_one_reg <= integ_one_next;
                integ_two_reg <= integ_two_next;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_accept) begin
                comb_one_d0_reg <= head_x;
                comb_one_d1_reg <= comb_one_d0_reg;
                comb_two_d0_reg <= comb_one_out;
                comb_two_d1_reg <= comb_two_d0_reg;
                if (m_last_of_word) begin
                    rd_idx_reg <= '0;
                    rd_ptr_reg <= ~rd_ptr_reg;
                end else begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    // Buffer payload
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_sample_reg[wr_ptr_reg] <= burst_sample;
            buf_len_reg[wr_ptr_reg]    <= burst_len;
        end
    end

    // Assertions
    a_buf_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg != 2'd3)
        else $error("sample buffer count out of range");

    a_head_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (buf_len_reg[rd_ptr_reg] != '0) &&
                    (CNT_W'(rd_idx_reg) < buf_len_reg[rd_ptr_reg]))
        else $error("read index beyond burst length");

    a_countdown_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        countdown_reg != '0)
        else $error("byte countdown reached zero");

    a_last_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_accept && m_last_of_word) |=> (rd_idx_reg == '0))
        else $error("read index not rewound after last sample of word");

endmodule
